// ----- hw/rtl/gcsv_pkg.sv -----
// Shared constants, types and the sine table generator for the velocity integrator.
`timescale 1ns / 1ps

package gcsv_pkg;

   // Field widths.
   localparam int ACCEL_W   = 16;
   localparam int PITCH_W   = 15;
   localparam int TIME_W    = 32;
   localparam int VEL_W     = 32;
   localparam int TERM_W    = 16;
   localparam int GRAV_W    = 12;
   localparam int DB_W      = 8;
   localparam int TRIG_W    = 15;
   localparam int WEIGHT_W  = 19;

   // Configuration port.
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND = 4'd1;
   localparam logic [GRAV_W-1:0]    GRAV_RESET   = 12'd2511;
   localparam logic [DB_W-1:0]      DB_RESET     = 8'd3;

   // Angle arithmetic in 1/64 degree.
   localparam int TRIG_TABLE_BITS_DEF = 10;
   localparam int TURN         = 23040;
   localparam int QUARTER      = 5760;
   localparam int HALF_QUARTER = 2880;
   localparam int ANGLE_W      = 15;
   localparam int REM_W        = 13;

   // Shared serial arithmetic units.
   localparam int MUL_A_W      = 32;
   localparam int MUL_B_W      = 18;
   localparam int MUL_P_W      = MUL_A_W + MUL_B_W;
   localparam int DIV_N_W      = 54;
   localparam int DIV_D_W      = 13;
   localparam int DIV_CNT_W    = $clog2(DIV_N_W + 1);
   localparam int STEP_DIVISOR = 375;
   localparam int STEP_ROUND   = 187;
   localparam int Q14_ROUND    = 8192;

   localparam logic [VEL_W-1:0] VEL_MAX = 32'h7FFF_FFFF;
   localparam logic [VEL_W-1:0] VEL_MIN = 32'h8000_0000;

   localparam longint Q30 = 64'sd1073741824;

   typedef enum logic [4:0] {
      S_IDLE,
      S_ANGLE,
      S_SIN_GO,
      S_SIN_WAIT,
      S_COS_GO,
      S_COS_WAIT,
      S_SHARE_GO,
      S_SHARE_WAIT,
      S_RESID,
      S_TERM_GO,
      S_TERM_WAIT,
      S_WEIGHT,
      S_STEP_GO,
      S_STEP_WAIT,
      S_DIV_GO,
      S_DIV_WAIT,
      S_ACCUM
   } state_type;

   // Quarter-wave sine entry k in Q14, from a Q30 odd polynomial of degree 9.
   // Evaluated at elaboration only.
   function automatic logic [TRIG_W-1:0] poly_sine(input int k, input int bits);
      longint u;
      longint u2;
      longint p;
      longint s;
      longint q;
      u  = longint'(k) * (Q30 >>> bits);
      u2 = (u * u) / Q30;
      p  = 64'sd172272;
      p  = -64'sd5026996 + (p * u2) / Q30;
      p  = 64'sd85569306 + (p * u2) / Q30;
      p  = -64'sd693598668 + (p * u2) / Q30;
      p  = 64'sd1686629713 + (p * u2) / Q30;
      s  = (p * u) / Q30;
      if (s < 0) begin
         q = -((-s + 64'sd32768) / 64'sd65536);
      end else begin
         q = (s + 64'sd32768) / 64'sd65536;
      end
      if (q < 0) begin
         q = 0;
      end else if (q > 64'sd16384) begin
         q = 64'sd16384;
      end
      return TRIG_W'(q);
   endfunction

endpackage

// ----- hw/rtl/gcsv_if.sv -----
// Request, response and register-write channel interfaces.
`timescale 1ns / 1ps

interface gcsv_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [gcsv_pkg::ACCEL_W-1:0]   accel_sample;
   logic signed [gcsv_pkg::PITCH_W-1:0]   pitch_angle;
   logic                                  orientation_ok;
   logic        [gcsv_pkg::TIME_W-1:0]    timestamp_ms;

   modport source (output valid, accel_sample, pitch_angle, orientation_ok, timestamp_ms,
                   input ready);
   modport sink   (input valid, accel_sample, pitch_angle, orientation_ok, timestamp_ms,
                   output ready);
endinterface

interface gcsv_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [gcsv_pkg::VEL_W-1:0]     velocity;
   logic signed [gcsv_pkg::VEL_W-1:0]     velocity_step;
   logic signed [gcsv_pkg::TERM_W-1:0]    horizontal_accel;

   modport source (output valid, velocity, velocity_step, horizontal_accel, input ready);
   modport sink   (input valid, velocity, velocity_step, horizontal_accel, output ready);
endinterface

interface gcsv_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [gcsv_pkg::CSR_IDX_W-1:0]        index;
   logic [gcsv_pkg::CSR_DATA_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/gravity_comp_simpson_velocity.sv -----
// Top level: gravity-compensated x-axis velocity integrator using Simpson's rule.
`timescale 1ns / 1ps

// Each request carries an x acceleration, a pitch angle, an orientation-valid flag and a
// millisecond timestamp, and produces exactly one response holding the saturated velocity,
// this request's Simpson increment and the gravity-compensated, cos-scaled acceleration
// term. One request is processed at a time by a sequencer that drives a bit-serial
// multiplier and a bit-serial divider (one quotient bit per cycle) plus a registered
// quarter-wave sine table. With the orientation flag set the response is loaded after
// two table index divisions, three products and the 54-bit division by 375 of the
// increment; with the flag clear only the increment is computed before it is loaded. The
// next request can be accepted in the cycle after the response is loaded. A finished
// response waits in an output register, so the next request is accepted while the
// previous response is still pending; the block only stalls at its very last step if that
// register is still occupied. The configuration channel is always ready and should only be
// written while no request is in flight. No clearing pass is needed after reset.
module gravity_comp_simpson_velocity #(
   parameter int TRIG_TABLE_BITS = gcsv_pkg::TRIG_TABLE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   gcsv_req_if.sink    req_if,
   gcsv_rsp_if.source  rsp_if,
   gcsv_csr_if.sink    csr_if
);

   localparam int IDX_NUM_W = TRIG_TABLE_BITS + 14;
   localparam int PAD_W     = gcsv_pkg::DIV_N_W - IDX_NUM_W;

   gcsv_pkg::state_type state_ff, state_in;

   // Configuration registers.
   logic [gcsv_pkg::GRAV_W-1:0] grav_ff;
   logic [gcsv_pkg::DB_W-1:0]   db_ff;

   // Latched request.
   logic signed [gcsv_pkg::ACCEL_W-1:0] accel_ff;
   logic signed [gcsv_pkg::PITCH_W-1:0] pitch_ff;
   logic        [gcsv_pkg::TIME_W-1:0]  ts_ff;

   // Working registers.
   logic [1:0]                         quad_ff;
   logic [gcsv_pkg::REM_W-1:0]         rem_ff;
   logic [gcsv_pkg::TRIG_W-1:0]        sin_mag_ff;
   logic [gcsv_pkg::TRIG_W-1:0]        cos_mag_ff;
   logic signed [12:0]                 share_ff;
   logic [15:0]                        resid_mag_ff;
   logic                               resid_neg_ff;
   logic signed [gcsv_pkg::TERM_W-1:0] term_ff;
   logic [gcsv_pkg::MUL_B_W-1:0]       w_mag_ff;
   logic                               w_neg_ff;
   logic [gcsv_pkg::TIME_W-1:0]        dt_ff;
   logic signed [gcsv_pkg::VEL_W-1:0]  step_ff;

   // History.
   logic signed [gcsv_pkg::TERM_W-1:0] prev_term_ff;
   logic signed [gcsv_pkg::TERM_W-1:0] prev_prev_term_ff;
   logic        [gcsv_pkg::TIME_W-1:0] prev_time_ff;
   logic        [gcsv_pkg::TIME_W-1:0] prev_prev_time_ff;
   logic signed [gcsv_pkg::VEL_W-1:0]  vel_sum_ff;

   // Response register.
   logic                               rsp_valid_ff;
   logic signed [gcsv_pkg::VEL_W-1:0]  rsp_vel_ff;
   logic signed [gcsv_pkg::VEL_W-1:0]  rsp_step_ff;
   logic signed [gcsv_pkg::TERM_W-1:0] rsp_accel_ff;

   // Shared units.
   logic                          mul_start;
   logic [gcsv_pkg::MUL_A_W-1:0]  mul_a;
   logic [gcsv_pkg::MUL_B_W-1:0]  mul_b;
   logic                          mul_done;
   logic [gcsv_pkg::MUL_P_W-1:0]  mul_prod;
   logic                          div_start;
   logic [gcsv_pkg::DIV_N_W-1:0]  div_numer;
   logic [gcsv_pkg::DIV_CNT_W-1:0] div_count;
   logic [gcsv_pkg::DIV_D_W-1:0]  div_divisor;
   logic                          div_done;
   logic [gcsv_pkg::DIV_N_W-1:0]  div_quot;
   logic [gcsv_pkg::TRIG_W-1:0]   rom_mag;

   logic req_fire;
   logic out_free;
   logic rsp_load;

   // Angle reduction to one turn, then quadrant and offset inside it.
   logic [16:0]                  ang_sum;
   logic [gcsv_pkg::ANGLE_W-1:0] ang_red;
   logic [1:0]                   quad_in;
   logic [gcsv_pkg::REM_W-1:0]   rem_in;

   // Table index numerators for sine and cosine.
   logic [1:0]                   cos_quad;
   logic [gcsv_pkg::REM_W-1:0]   sin_off;
   logic [gcsv_pkg::REM_W-1:0]   cos_off;
   logic [IDX_NUM_W-1:0]         sin_num;
   logic [IDX_NUM_W-1:0]         cos_num;

   // Datapath results.
   logic [25:0]                  share_rnd;
   logic signed [16:0]           resid;
   logic [16:0]                  resid_abs;
   logic [30:0]                  term_rnd;
   logic [16:0]                  term_mag;
   logic signed [gcsv_pkg::TERM_W-1:0] term_in;
   logic signed [gcsv_pkg::WEIGHT_W-1:0] weight;
   logic [gcsv_pkg::WEIGHT_W-1:0] weight_abs;
   logic signed [gcsv_pkg::VEL_W-1:0] step_in;
   logic [32:0]                  vel_wide;
   logic signed [gcsv_pkg::VEL_W-1:0] vel_in;

   assign req_fire = req_if.valid && req_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign rsp_load = (state_ff == gcsv_pkg::S_ACCUM) && out_free;

   assign req_if.ready = (state_ff == gcsv_pkg::S_IDLE);
   assign csr_if.ready = 1'b1;

   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.velocity         = rsp_vel_ff;
   assign rsp_if.velocity_step    = rsp_step_ff;
   assign rsp_if.horizontal_accel = rsp_accel_ff;

   gcsv_mul #(
      .A_W (gcsv_pkg::MUL_A_W),
      .B_W (gcsv_pkg::MUL_B_W)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   gcsv_div #(
      .N_W (gcsv_pkg::DIV_N_W),
      .D_W (gcsv_pkg::DIV_D_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_numer),
      .count    (div_count),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   // The table address follows the divider quotient; the index is never above 2^bits.
   gcsv_trig #(
      .TAB_BITS (TRIG_TABLE_BITS)
   ) u_trig (
      .clock (clock),
      .addr  (div_quot[TRIG_TABLE_BITS:0]),
      .mag   (rom_mag)
   );

   // Angle: the sign-extended pitch plus one turn is positive and below two turns.
   always_comb begin
      ang_sum = 17'(pitch_ff) + 17'(gcsv_pkg::TURN);
      ang_red = (ang_sum >= 17'(gcsv_pkg::TURN)) ? gcsv_pkg::ANGLE_W'(ang_sum - 17'(gcsv_pkg::TURN))
                                                 : gcsv_pkg::ANGLE_W'(ang_sum);
      if (ang_red >= gcsv_pkg::ANGLE_W'(3 * gcsv_pkg::QUARTER)) begin
         quad_in = 2'd3;
         rem_in  = gcsv_pkg::REM_W'(ang_red - gcsv_pkg::ANGLE_W'(3 * gcsv_pkg::QUARTER));
      end else if (ang_red >= gcsv_pkg::ANGLE_W'(2 * gcsv_pkg::QUARTER)) begin
         quad_in = 2'd2;
         rem_in  = gcsv_pkg::REM_W'(ang_red - gcsv_pkg::ANGLE_W'(2 * gcsv_pkg::QUARTER));
      end else if (ang_red >= gcsv_pkg::ANGLE_W'(gcsv_pkg::QUARTER)) begin
         quad_in = 2'd1;
         rem_in  = gcsv_pkg::REM_W'(ang_red - gcsv_pkg::ANGLE_W'(gcsv_pkg::QUARTER));
      end else begin
         quad_in = 2'd0;
         rem_in  = gcsv_pkg::REM_W'(ang_red);
      end
   end

   // Odd quadrants read the table mirrored; cosine is sine one quadrant later.
   always_comb begin
      cos_quad = quad_ff + 2'd1;
      sin_off  = quad_ff[0]  ? gcsv_pkg::REM_W'(gcsv_pkg::QUARTER) - rem_ff : rem_ff;
      cos_off  = cos_quad[0] ? gcsv_pkg::REM_W'(gcsv_pkg::QUARTER) - rem_ff : rem_ff;
      sin_num  = {1'b0, sin_off, {TRIG_TABLE_BITS{1'b0}}} + IDX_NUM_W'(gcsv_pkg::HALF_QUARTER);
      cos_num  = {1'b0, cos_off, {TRIG_TABLE_BITS{1'b0}}} + IDX_NUM_W'(gcsv_pkg::HALF_QUARTER);
   end

   // Arithmetic on the unit results, all rounded half away from zero on magnitudes.
   always_comb begin
      share_rnd = 26'(mul_prod) + 26'(gcsv_pkg::Q14_ROUND);

      resid     = 17'(accel_ff) - 17'(share_ff);
      resid_abs = resid[16] ? 17'(17'd0 - resid) : 17'(resid);

      term_rnd  = 31'(mul_prod) + 31'(gcsv_pkg::Q14_ROUND);
      term_mag  = term_rnd[30:14];
      if (resid_neg_ff ^ cos_quad[1]) begin
         term_in = (term_mag >= 17'd32768) ? 16'sh8000 : 16'(17'd0 - term_mag);
      end else begin
         term_in = (term_mag > 17'd32767) ? 16'sh7FFF : 16'(term_mag);
      end

      weight     = gcsv_pkg::WEIGHT_W'(prev_prev_term_ff)
                 + (gcsv_pkg::WEIGHT_W'(prev_term_ff) <<< 2)
                 + gcsv_pkg::WEIGHT_W'(term_ff);
      weight_abs = weight[gcsv_pkg::WEIGHT_W-1] ? gcsv_pkg::WEIGHT_W'(-weight)
                                                : gcsv_pkg::WEIGHT_W'(weight);

      // The increment quotient is a magnitude; limit it to the signed 32-bit range.
      if (w_neg_ff) begin
         step_in = ((|div_quot[gcsv_pkg::DIV_N_W-1:32]) || (div_quot[31] && (|div_quot[30:0])))
                 ? gcsv_pkg::VEL_MIN : 32'(gcsv_pkg::DIV_N_W'(0) - div_quot);
      end else begin
         step_in = (|div_quot[gcsv_pkg::DIV_N_W-1:31]) ? gcsv_pkg::VEL_MAX : 32'(div_quot);
      end

      vel_wide = {vel_sum_ff[31], vel_sum_ff} + {step_ff[31], step_ff};
      if (vel_wide[32] != vel_wide[31]) begin
         vel_in = vel_wide[32] ? gcsv_pkg::VEL_MIN : gcsv_pkg::VEL_MAX;
      end else begin
         vel_in = vel_wide[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gcsv_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequencer: next state and unit starts with their operands.
   always_comb begin
      state_in    = state_ff;
      mul_start   = 1'b0;
      mul_a       = gcsv_pkg::MUL_A_W'(grav_ff);
      mul_b       = gcsv_pkg::MUL_B_W'(sin_mag_ff);
      div_start   = 1'b0;
      div_numer   = {sin_num, {PAD_W{1'b0}}};
      div_count   = gcsv_pkg::DIV_CNT_W'(IDX_NUM_W);
      div_divisor = gcsv_pkg::DIV_D_W'(gcsv_pkg::QUARTER);
      case (state_ff)
         gcsv_pkg::S_IDLE: begin
            if (req_fire) begin
               state_in = req_if.orientation_ok ? gcsv_pkg::S_ANGLE : gcsv_pkg::S_WEIGHT;
            end
         end
         gcsv_pkg::S_ANGLE: begin
            state_in = gcsv_pkg::S_SIN_GO;
         end
         gcsv_pkg::S_SIN_GO: begin
            div_start = 1'b1;
            state_in  = gcsv_pkg::S_SIN_WAIT;
         end
         gcsv_pkg::S_SIN_WAIT: begin
            if (div_done) begin
               state_in = gcsv_pkg::S_COS_GO;
            end
         end
         gcsv_pkg::S_COS_GO: begin
            div_start = 1'b1;
            div_numer = {cos_num, {PAD_W{1'b0}}};
            state_in  = gcsv_pkg::S_COS_WAIT;
         end
         gcsv_pkg::S_COS_WAIT: begin
            if (div_done) begin
               state_in = gcsv_pkg::S_SHARE_GO;
            end
         end
         gcsv_pkg::S_SHARE_GO: begin
            mul_start = 1'b1;
            state_in  = gcsv_pkg::S_SHARE_WAIT;
         end
         gcsv_pkg::S_SHARE_WAIT: begin
            if (mul_done) begin
               state_in = gcsv_pkg::S_RESID;
            end
         end
         gcsv_pkg::S_RESID: begin
            state_in = gcsv_pkg::S_TERM_GO;
         end
         gcsv_pkg::S_TERM_GO: begin
            mul_start = 1'b1;
            mul_a     = gcsv_pkg::MUL_A_W'(resid_mag_ff);
            mul_b     = gcsv_pkg::MUL_B_W'(cos_mag_ff);
            state_in  = gcsv_pkg::S_TERM_WAIT;
         end
         gcsv_pkg::S_TERM_WAIT: begin
            if (mul_done) begin
               state_in = gcsv_pkg::S_WEIGHT;
            end
         end
         gcsv_pkg::S_WEIGHT: begin
            state_in = gcsv_pkg::S_STEP_GO;
         end
         gcsv_pkg::S_STEP_GO: begin
            mul_start = 1'b1;
            mul_a     = dt_ff;
            mul_b     = w_mag_ff;
            state_in  = gcsv_pkg::S_STEP_WAIT;
         end
         gcsv_pkg::S_STEP_WAIT: begin
            if (mul_done) begin
               state_in = gcsv_pkg::S_DIV_GO;
            end
         end
         gcsv_pkg::S_DIV_GO: begin
            // Numerator is dt*|weight|*16 plus half the divisor, for rounding.
            div_start   = 1'b1;
            div_numer   = {mul_prod, 4'b0000} + gcsv_pkg::DIV_N_W'(gcsv_pkg::STEP_ROUND);
            div_count   = gcsv_pkg::DIV_CNT_W'(gcsv_pkg::DIV_N_W);
            div_divisor = gcsv_pkg::DIV_D_W'(gcsv_pkg::STEP_DIVISOR);
            state_in    = gcsv_pkg::S_DIV_WAIT;
         end
         gcsv_pkg::S_DIV_WAIT: begin
            if (div_done) begin
               state_in = gcsv_pkg::S_ACCUM;
            end
         end
         gcsv_pkg::S_ACCUM: begin
            if (out_free) begin
               state_in = gcsv_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = gcsv_pkg::S_IDLE;
         end
      endcase
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         grav_ff <= gcsv_pkg::GRAV_RESET;
         db_ff   <= gcsv_pkg::DB_RESET;
      end else if (csr_if.valid && csr_if.ready) begin
         case (csr_if.index)
            gcsv_pkg::CSR_GRAVITY:  grav_ff <= csr_if.data[gcsv_pkg::GRAV_W-1:0];
            gcsv_pkg::CSR_DEADBAND: db_ff   <= csr_if.data[gcsv_pkg::DB_W-1:0];
            default: ;
         endcase
      end
   end

   // Working registers, loaded as the sequencer passes each step.
   always_ff @(posedge clock) begin
      case (state_ff)
         gcsv_pkg::S_IDLE: begin
            if (req_fire) begin
               accel_ff <= req_if.accel_sample;
               pitch_ff <= req_if.pitch_angle;
               ts_ff    <= req_if.timestamp_ms;
               term_ff  <= '0;
            end
         end
         gcsv_pkg::S_ANGLE: begin
            quad_ff <= quad_in;
            rem_ff  <= rem_in;
         end
         gcsv_pkg::S_COS_GO: begin
            sin_mag_ff <= rom_mag;
         end
         gcsv_pkg::S_SHARE_GO: begin
            cos_mag_ff <= rom_mag;
         end
         gcsv_pkg::S_SHARE_WAIT: begin
            if (mul_done) begin
               share_ff <= quad_ff[1] ? 13'(13'sd0 - 13'(share_rnd[25:14]))
                                      : 13'(share_rnd[25:14]);
            end
         end
         gcsv_pkg::S_RESID: begin
            resid_neg_ff <= resid[16];
            resid_mag_ff <= (resid_abs <= 17'(db_ff)) ? 16'd0 : 16'(resid_abs);
         end
         gcsv_pkg::S_TERM_WAIT: begin
            if (mul_done) begin
               term_ff <= term_in;
            end
         end
         gcsv_pkg::S_WEIGHT: begin
            w_neg_ff <= weight[gcsv_pkg::WEIGHT_W-1];
            w_mag_ff <= gcsv_pkg::MUL_B_W'(weight_abs);
            dt_ff    <= ts_ff - prev_prev_time_ff;
         end
         gcsv_pkg::S_DIV_WAIT: begin
            if (div_done) begin
               step_ff <= step_in;
            end
         end
         default: ;
      endcase
   end

   // History and accumulator advance when the response is handed over.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_term_ff      <= '0;
         prev_prev_term_ff <= '0;
         prev_time_ff      <= '0;
         prev_prev_time_ff <= '0;
         vel_sum_ff        <= '0;
      end else if (rsp_load) begin
         prev_term_ff      <= term_ff;
         prev_prev_term_ff <= prev_term_ff;
         prev_time_ff      <= ts_ff;
         prev_prev_time_ff <= prev_time_ff;
         vel_sum_ff        <= vel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_vel_ff   <= vel_in;
         rsp_step_ff  <= step_ff;
         rsp_accel_ff <= term_ff;
      end
   end

   // The response carries the accumulator and term that were just committed.
   a_rsp_vel: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_if.velocity == vel_sum_ff))
      else $error("response velocity differs from the accumulator");

   a_rsp_term: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_if.horizontal_accel == prev_term_ff))
      else $error("response term differs from the stored history");

   a_units_apart: assert property (@(posedge clock) disable iff (reset)
      !(mul_done && div_done))
      else $error("multiplier and divider finished together");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != gcsv_pkg::S_IDLE))
      else $error("accepted request did not start the sequencer");

   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == gcsv_pkg::S_ACCUM) && !out_free) |=> (state_ff == gcsv_pkg::S_ACCUM))
      else $error("result step left while the response register was full");

endmodule

// ----- hw/rtl/gcsv_mul.sv -----
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps

module gcsv_mul #(
   parameter int A_W = gcsv_pkg::MUL_A_W,
   parameter int B_W = gcsv_pkg::MUL_B_W
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [A_W-1:0]     a,
   input  logic [B_W-1:0]     b,
   output logic               done,
   output logic [A_W+B_W-1:0] product
);

   localparam int CNT_W = $clog2(B_W + 1);

   logic [A_W-1:0]     a_ff;
   logic [A_W+B_W-1:0] prod_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               busy_ff;
   logic               done_ff;
   logic [A_W:0]       sum;

   // Add the multiplicand into the upper half when the low bit is set, then shift right.
   assign sum = {1'b0, prod_ff[A_W+B_W-1:B_W]} + (prod_ff[0] ? {1'b0, a_ff} : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= CNT_W'(B_W);
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff    <= a;
         prod_ff <= {{A_W{1'b0}}, b};
      end else if (busy_ff) begin
         prod_ff <= {sum, prod_ff[B_W-1:1]};
      end
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

// ----- hw/rtl/gcsv_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle, numerator left-aligned.
`timescale 1ns / 1ps

module gcsv_div #(
   parameter int N_W = gcsv_pkg::DIV_N_W,
   parameter int D_W = gcsv_pkg::DIV_D_W
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [N_W-1:0]             numer,
   input  logic [$clog2(N_W+1)-1:0]   count,
   input  logic [D_W-1:0]             divisor,
   output logic                       done,
   output logic [N_W-1:0]             quotient
);

   localparam int CNT_W = $clog2(N_W + 1);

   logic [N_W-1:0]   num_ff;
   logic [N_W-1:0]   quot_ff;
   logic [D_W-1:0]   rem_ff;
   logic [D_W-1:0]   dvs_ff;
   logic [CNT_W-1:0] count_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [D_W:0]     trial;
   logic             fits;

   assign trial = {rem_ff, num_ff[N_W-1]};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= count;
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff  <= numer;
         quot_ff <= '0;
         rem_ff  <= '0;
         dvs_ff  <= divisor;
      end else if (busy_ff) begin
         num_ff  <= {num_ff[N_W-2:0], 1'b0};
         quot_ff <= {quot_ff[N_W-2:0], fits};
         rem_ff  <= fits ? D_W'(trial - {1'b0, dvs_ff}) : D_W'(trial);
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// ----- hw/rtl/gcsv_trig.sv -----
// Quarter-wave sine table in Q14 with a registered read.
`timescale 1ns / 1ps

module gcsv_trig #(
   parameter int TAB_BITS = gcsv_pkg::TRIG_TABLE_BITS_DEF
) (
   input  logic                        clock,
   input  logic [TAB_BITS:0]           addr,
   output logic [gcsv_pkg::TRIG_W-1:0] mag
);

   localparam int TAB_LEN = (1 << TAB_BITS) + 1;

   logic [gcsv_pkg::TRIG_W-1:0] tab [TAB_LEN];
   logic [gcsv_pkg::TRIG_W-1:0] mag_ff;
   logic [TAB_BITS:0]           addr_clip;

   for (genvar k = 0; k < TAB_LEN; k++) begin : g_tab
      assign tab[k] = gcsv_pkg::poly_sine(k, TAB_BITS);
   end

   assign addr_clip = (addr > (TAB_BITS+1)'(TAB_LEN - 1)) ? (TAB_BITS+1)'(TAB_LEN - 1) : addr;

   always_ff @(posedge clock) begin
      mag_ff <= tab[addr_clip];
   end

   assign mag = mag_ff;

endmodule
